/* rtl/r2nv_pkg.sv */
`default_nettype none
// ============================================================================
// r2nv_pkg: shared types and constants for the RGB to NV12 converter
// Holds the payload structs, the register reset value and the BT.601
// coefficients used by the color conversion stage.
// ============================================================================
package r2nv_pkg;

    localparam int CFG_W             = 11;
    localparam int MAX_PAIRS_DEFAULT = 1024;
    localparam logic [CFG_W-1:0] PAIRS_RESET = 11'd320;

    // Width of one chroma term and of a pair sum.
    localparam int TERM_W = 8;
    localparam int PAIR_W = TERM_W + 1;

    // BT.601 coefficients, magnitudes only; signs are applied in the datapath.
    localparam logic [7:0] Y_R  = 8'd66;
    localparam logic [7:0] Y_G  = 8'd129;
    localparam logic [7:0] Y_B  = 8'd25;
    localparam logic [7:0] CB_R = 8'd38;
    localparam logic [7:0] CB_G = 8'd74;
    localparam logic [7:0] CB_B = 8'd112;
    localparam logic [7:0] CR_R = 8'd112;
    localparam logic [7:0] CR_G = 8'd94;
    localparam logic [7:0] CR_B = 8'd18;
    localparam logic [16:0] ROUND_BIAS  = 17'd128;
    // Offset of 128 * 256 keeps the chroma sums nonnegative before the shift.
    localparam logic [16:0] CHROMA_OFFS = 17'd32768;
    localparam logic [7:0]  LUMA_OFFS   = 8'd16;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       start_of_frame;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] cb;
        logic [7:0] cr;
    } pixel_out_t;

    // Per-pixel position flags that travel down the pipeline.
    typedef struct packed {
        logic second;  // second pixel of a pair
        logic bottom;  // bottom row of a row pair
    } pix_ctrl_t;

    typedef struct packed {
        logic [7:0]        luma;
        logic [TERM_W-1:0] cb;
        logic [TERM_W-1:0] cr;
    } term_t;

endpackage : r2nv_pkg
`default_nettype wire

/* rtl/r2nv_ram.sv */
`default_nettype none
// ============================================================================
// r2nv_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module r2nv_ram #(
    parameter int WIDTH  = 18,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : r2nv_ram
`default_nettype wire

/* rtl/r2nv_seq.sv */
`default_nettype none
// ============================================================================
// r2nv_seq: raster position sequencer
// Tracks pair column, pixel phase and row parity, and labels each accepted
// pixel with its position in the 2x2 block.
// ============================================================================
module r2nv_seq
    import r2nv_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEFAULT,
    parameter int ADDR_W    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic              sof,
    input  wire logic [CFG_W-1:0]  pairs_per_line,
    output pix_ctrl_t              ctrl,
    output logic      [ADDR_W-1:0] col
);

    localparam int CMP_W = (ADDR_W + 2 > CFG_W) ? ADDR_W + 2 : CFG_W;
    localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_PAIRS);

    logic [ADDR_W-1:0] col_reg, col_next;
    logic              phase_reg, phase_next;
    logic              bottom_reg, bottom_next;
    logic [CMP_W-1:0]  pairs_ext;
    logic [CMP_W-1:0]  eff_pairs;
    logic              line_end;

    // Start of frame clears the position before the pixel is labeled.
    always_comb begin
        ctrl.second = sof ? 1'b0 : phase_reg;
        ctrl.bottom = sof ? 1'b0 : bottom_reg;
        col         = sof ? '0 : col_reg;
    end

    always_comb begin
        pairs_ext = CMP_W'(pairs_per_line);
        if (pairs_ext == '0) begin
            eff_pairs = CMP_W'(1);
        end else if (pairs_ext > MAX_EXT) begin
            eff_pairs = MAX_EXT;
        end else begin
            eff_pairs = pairs_ext;
        end
        line_end = (CMP_W'(col) + CMP_W'(1)) >= eff_pairs;
    end

    always_comb begin
        col_next    = col_reg;
        phase_next  = phase_reg;
        bottom_next = bottom_reg;
        if (accept) begin
            if (!ctrl.second) begin
                col_next    = col;
                phase_next  = 1'b1;
                bottom_next = ctrl.bottom;
            end else begin
                phase_next = 1'b0;
                if (line_end) begin
                    col_next    = '0;
                    bottom_next = !ctrl.bottom;
                end else begin
                    col_next    = col + ADDR_W'(1);
                    bottom_next = ctrl.bottom;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            phase_reg  <= 1'b0;
            bottom_reg <= 1'b0;
        end else begin
            col_reg    <= col_next;
            phase_reg  <= phase_next;
            bottom_reg <= bottom_next;
        end
    end

endmodule : r2nv_seq
`default_nettype wire

/* rtl/r2nv_csc.sv */
`default_nettype none
// ============================================================================
// r2nv_csc: BT.601 color conversion stage
// Computes luma and the per-pixel Cb and Cr terms from one RGB pixel and
// registers them.
// ============================================================================
module r2nv_csc
    import r2nv_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       load,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    output term_t           terms
);

    logic [16:0] y_sum;
    logic [16:0] cb_sum;
    logic [16:0] cr_sum;
    term_t       terms_next;

    // The chroma sums stay within 0..65535 thanks to the offset, so modular
    // arithmetic on 17 bits gives the exact value.
    always_comb begin
        y_sum  = 17'(Y_R) * 17'(red) + 17'(Y_G) * 17'(green)
                 + 17'(Y_B) * 17'(blue) + ROUND_BIAS;
        cb_sum = 17'(CB_B) * 17'(blue) + ROUND_BIAS + CHROMA_OFFS
                 - 17'(CB_R) * 17'(red) - 17'(CB_G) * 17'(green);
        cr_sum = 17'(CR_R) * 17'(red) + ROUND_BIAS + CHROMA_OFFS
                 - 17'(CR_G) * 17'(green) - 17'(CR_B) * 17'(blue);
        terms_next.luma = y_sum[15:8] + LUMA_OFFS;
        terms_next.cb   = cb_sum[15:8];
        terms_next.cr   = cr_sum[15:8];
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            terms <= terms_next;
        end
    end

endmodule : r2nv_csc
`default_nettype wire

/* rtl/rgb_to_nv12_converter.sv */
`default_nettype none
// ============================================================================
// rgb_to_nv12_converter: RGB to BT.601 luma and 4:2:0 chroma
// Raster RGB pixels in, one luma per pixel out, with averaged Cb and Cr on
// the second pixel of each bottom-row pair.
// ============================================================================
// The block takes one pixel per clock while the output side is ready, and
// gives one result per pixel from its output register. Pair sums of
// the top row go into a line RAM of MAX_PAIRS entries and are read back when
// the matching bottom-row pair completes; the RAM write comes from the last
// pipeline stage and the read is issued one stage earlier, so a later pixel
// always sees the sum written for it. The line RAM needs no clearing after
// reset, as every entry is written on a top row before it is read. Write
// pairs_per_line only while no pixel is in flight; start_of_frame restarts
// the position at the first pixel of the top row.
module rgb_to_nv12_converter
    import r2nv_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire pixel_in_t        s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output pixel_out_t            m_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int ADDR_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int SUM_W  = 2 * PAIR_W;

    logic [CFG_W-1:0] pairs_reg;

    logic              accept;
    logic              en_out, en_s2, en_s1;
    pix_ctrl_t         in_ctrl;
    logic [ADDR_W-1:0] in_col;

    logic              s1_valid_reg;
    logic [7:0]        s1_red_reg, s1_green_reg, s1_blue_reg;
    pix_ctrl_t         s1_ctrl_reg;
    logic [ADDR_W-1:0] s1_col_reg;

    logic              s2_valid_reg;
    pix_ctrl_t         s2_ctrl_reg;
    logic [ADDR_W-1:0] s2_col_reg;
    term_t             s2_terms;
    logic [SUM_W-1:0]  line_rd_data;

    logic [TERM_W-1:0] pend_cb_reg, pend_cr_reg;

    logic [PAIR_W-1:0] pair_cb, pair_cr;
    logic [PAIR_W:0]   tot_cb, tot_cr;
    logic              line_wr_en;
    pixel_out_t        out_next;
    logic              m_valid_reg;
    pixel_out_t        m_data_reg;

    // Configuration register, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pairs_reg <= PAIRS_RESET;
        end else if (cfg_valid) begin
            pairs_reg <= cfg_data;
        end
    end

    // Each stage loads when it is empty or its contents move on.
    assign en_out  = !m_valid_reg || m_ready;
    assign en_s2   = !s2_valid_reg || en_out;
    assign en_s1   = !s1_valid_reg || en_s2;
    assign s_ready = en_s1;
    assign accept  = s_valid && en_s1;

    r2nv_seq #(
        .MAX_PAIRS (MAX_PAIRS),
        .ADDR_W    (ADDR_W)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .sof            (s_data.start_of_frame),
        .pairs_per_line (pairs_reg),
        .ctrl           (in_ctrl),
        .col            (in_col)
    );

    // Stage 1: captured pixel and its position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en_s1) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_s1) begin
            s1_red_reg   <= s_data.red;
            s1_green_reg <= s_data.green;
            s1_blue_reg  <= s_data.blue;
            s1_ctrl_reg  <= in_ctrl;
            s1_col_reg   <= in_col;
        end
    end

    // Stage 2: color terms and the line RAM read, both loaded on en_s2.
    r2nv_csc u_csc (
        .aclk  (aclk),
        .load  (en_s2),
        .red   (s1_red_reg),
        .green (s1_green_reg),
        .blue  (s1_blue_reg),
        .terms (s2_terms)
    );

    r2nv_ram #(
        .WIDTH  (SUM_W),
        .DEPTH  (MAX_PAIRS),
        .ADDR_W (ADDR_W)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (line_wr_en),
        .wr_addr (s2_col_reg),
        .wr_data ({pair_cr, pair_cb}),
        .rd_en   (en_s2),
        .rd_addr (s1_col_reg),
        .rd_data (line_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en_s2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_s2) begin
            s2_ctrl_reg <= s1_ctrl_reg;
            s2_col_reg  <= s1_col_reg;
        end
    end

    // Stage 3: pair sums, line store update and the 2x2 average.
    always_comb begin
        pair_cb = PAIR_W'(pend_cb_reg) + PAIR_W'(s2_terms.cb);
        pair_cr = PAIR_W'(pend_cr_reg) + PAIR_W'(s2_terms.cr);
        tot_cb  = (PAIR_W + 1)'(pair_cb) + (PAIR_W + 1)'(line_rd_data[PAIR_W-1:0]);
        tot_cr  = (PAIR_W + 1)'(pair_cr) + (PAIR_W + 1)'(line_rd_data[SUM_W-1:PAIR_W]);
        line_wr_en = en_out && s2_valid_reg && s2_ctrl_reg.second && !s2_ctrl_reg.bottom;

        out_next.luma         = s2_terms.luma;
        out_next.chroma_valid = s2_ctrl_reg.second && s2_ctrl_reg.bottom;
        out_next.cb           = out_next.chroma_valid ? tot_cb[PAIR_W:2] : '0;
        out_next.cr           = out_next.chroma_valid ? tot_cr[PAIR_W:2] : '0;
    end

    // The first pixel of a pair parks its terms here until its partner arrives.
    always_ff @(posedge aclk) begin
        if (en_out && s2_valid_reg && !s2_ctrl_reg.second) begin
            pend_cb_reg <= s2_terms.cb;
            pend_cr_reg <= s2_terms.cr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en_out) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule : rgb_to_nv12_converter
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench for the RGB to NV12 converter
// Sends raster RGB pixels and line-length writes with random gaps and stalls
// on both channels. A scoreboard predicts the luma and the 2x2 averaged
// chroma of every accepted pixel and checks each result in order.
// ============================================================================
module tb_top;
    import r2nv_pkg::*;

    localparam int LINE_MAX = MAX_PAIRS_DEFAULT;

    class nv12_scoreboard;
        pixel_out_t       awaited[$];
        logic [CFG_W-1:0] pairs_cfg;
        int               pair_col;
        bit               second_pixel;
        bit               on_bottom;
        logic [17:0]      first_terms;
        logic [17:0]      top_sums [LINE_MAX];
        bit               top_written [LINE_MAX];
        int unsigned      errors;

        function new();
            pairs_cfg    = PAIRS_RESET;
            pair_col     = 0;
            second_pixel = 1'b0;
            on_bottom    = 1'b0;
            first_terms  = '0;
            errors       = 0;
            foreach (top_sums[i]) begin
                top_sums[i]    = '0;
                top_written[i] = 1'b0;
            end
        endfunction

        function int line_pairs(logic [CFG_W-1:0] v);
            if (v == 0) return 1;
            if (v > LINE_MAX) return LINE_MAX;
            return int'(v);
        endfunction

        function void set_pairs(logic [CFG_W-1:0] v);
            pairs_cfg = v;
        endfunction

        // A bottom row may not run into line-store entries that no top row has
        // filled yet; in that case the next frame has to start afresh.
        function bit needs_restart(logic [CFG_W-1:0] v);
            int last;
            last = line_pairs(v) - 1;
            if (!on_bottom) return 1'b0;
            if (last < pair_col) last = pair_col;
            for (int c = pair_col; c <= last; c++) begin
                if (!top_written[c]) return 1'b1;
            end
            return 1'b0;
        endfunction

        // Floor shift of the biased sum, then the 128 offset.
        function logic [8:0] chroma_term(int sum);
            int t;
            t = ((sum + 128) >>> 8) + 128;
            return 9'(t);
        endfunction

        function void note_pixel(pixel_in_t px);
            int         r, g, b;
            logic [8:0] cb_t, cr_t, cb_pair, cr_pair;
            logic [9:0] cb_tot, cr_tot;
            pixel_out_t res;
            r = px.red;
            g = px.green;
            b = px.blue;
            if (px.start_of_frame) begin
                pair_col     = 0;
                second_pixel = 1'b0;
                on_bottom    = 1'b0;
            end
            res      = '0;
            res.luma = 8'(((66 * r + 129 * g + 25 * b + 128) >> 8) + 16);
            cb_t     = chroma_term(112 * b - 38 * r - 74 * g);
            cr_t     = chroma_term(112 * r - 94 * g - 18 * b);
            if (!second_pixel) begin
                first_terms  = {cr_t, cb_t};
                second_pixel = 1'b1;
            end else begin
                cb_pair = first_terms[8:0] + cb_t;
                cr_pair = first_terms[17:9] + cr_t;
                if (!on_bottom) begin
                    top_sums[pair_col]    = {cr_pair, cb_pair};
                    top_written[pair_col] = 1'b1;
                end else begin
                    cb_tot = {1'b0, cb_pair} + {1'b0, top_sums[pair_col][8:0]};
                    cr_tot = {1'b0, cr_pair} + {1'b0, top_sums[pair_col][17:9]};
                    res.chroma_valid = 1'b1;
                    res.cb           = cb_tot[9:2];
                    res.cr           = cr_tot[9:2];
                end
                second_pixel = 1'b0;
                if (pair_col + 1 >= line_pairs(pairs_cfg)) begin
                    pair_col  = 0;
                    on_bottom = !on_bottom;
                end else begin
                    pair_col++;
                end
            end
            awaited.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(pixel_out_t got);
            pixel_out_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("luma", want.luma, got.luma);
            compare_field("chroma_valid", 8'(want.chroma_valid), 8'(got.chroma_valid));
            compare_field("cb", want.cb, got.cb);
            compare_field("cr", want.cr, got.cr);
        endfunction
    endclass

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    pixel_in_t        s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    pixel_out_t       m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    bit calm      = 1'b0;  // no idling on either side while set
    bit stall_req = 1'b0;  // asks the receiver for one long hold-off

    nv12_scoreboard sb = new();

    rgb_to_nv12_converter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.set_pairs(cfg_data);
            if (s_valid && s_ready) sb.note_pixel(s_data);
            if (m_valid && m_ready) sb.check_pixel(m_data);
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin : sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                stall_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 27);
            end
        end
    end

    // Called at a clock edge; returns at the edge where the transfer happens.
    task automatic send_pixel(input pixel_in_t px);
        if (!calm && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 27);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_rgb(input logic [7:0] r, g, b, input logic sof);
        pixel_in_t px;
        px.red            = r;
        px.green          = g;
        px.blue           = b;
        px.start_of_frame = sof;
        send_pixel(px);
    endtask

    // Step one edge first so that a transfer at the current edge is noted.
    task automatic wait_drained();
        @(posedge aclk);
        while (sb.awaited.size() != 0) @(posedge aclk);
    endtask

    task automatic write_pairs(input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly random levels, with the rails picked often.
    function automatic logic [7:0] pick_level();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One line length, n pixels; sof_odds of 0 means no start of frame
    // except possibly on the first pixel.
    task automatic run_phase(input logic [CFG_W-1:0] v, input int n, input int sof_odds);
        bit restart;
        bit sof;
        wait_drained();
        restart = sb.needs_restart(v) || ($urandom_range(1) == 1);
        write_pairs(v);
        for (int i = 0; i < n; i++) begin
            sof = (i == 0 && restart) ||
                  (sof_odds != 0 && $urandom_range(sof_odds - 1) == 0);
            send_rgb(pick_level(), pick_level(), pick_level(), sof);
        end
        s_valid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // One pair per line, so every four pixels complete a chroma block.
        write_pairs(11'd1);
        send_rgb(8'd0,   8'd0,   8'd0,   1'b1);
        send_rgb(8'd255, 8'd255, 8'd255, 1'b0);
        send_rgb(8'd255, 8'd0,   8'd0,   1'b0);
        send_rgb(8'd0,   8'd0,   8'd255, 1'b0);
        send_rgb(8'd0,   8'd255, 8'd0,   1'b0);
        send_rgb(8'd0,   8'd255, 8'd255, 1'b0);
        send_rgb(8'd255, 8'd0,   8'd255, 1'b0);
        send_rgb(8'd255, 8'd255, 8'd0,   1'b0);
        repeat (4) send_rgb(8'd0, 8'd0, 8'd255, 1'b0);
        send_rgb(8'd255, 8'd255, 8'd0,   1'b0);
        send_rgb(8'd255, 8'd255, 8'd0,   1'b0);
        send_rgb(8'd255, 8'd0,   8'd0,   1'b0);
        send_rgb(8'd255, 8'd0,   8'd0,   1'b0);
        // A start of frame in the middle of a bottom-row pair.
        send_rgb(8'd10,  8'd20,  8'd30,  1'b0);
        send_rgb(8'd40,  8'd50,  8'd60,  1'b0);
        send_rgb(8'd70,  8'd80,  8'd90,  1'b0);
        send_rgb(8'd200, 8'd100, 8'd50,  1'b1);
        send_rgb(8'd1,   8'd2,   8'd3,   1'b0);
        send_rgb(8'd128, 8'd128, 8'd128, 1'b0);
        send_rgb(8'd127, 8'd127, 8'd127, 1'b0);
        s_valid <= 1'b0;

        // A line length of zero behaves as one pair.
        run_phase(11'd0, 50, 0);
        run_phase(11'd3, 70, 60);
        run_phase(11'd2, 70, 60);
        calm = 1'b1;
        run_phase(11'd6, 100, 0);
        calm = 1'b0;
        wait_drained();
        stall_req = 1'b1;
        run_phase(11'd5, 80, 60);
        run_phase(11'd1, 50, 40);
        run_phase(11'd4, 60, 60);
        run_phase(11'd9, 70, 60);
        // Wide line settings; the all-ones value is clamped to the store size.
        run_phase(11'd2047, 40, 0);
        run_phase(11'd1024, 40, 0);
        run_phase(11'd3, 40, 30);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("[rgb_to_nv12_converter] OK");
        end else begin
            $display("[rgb_to_nv12_converter] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("[rgb_to_nv12_converter] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/r2nv_pkg.sv
rtl/r2nv_ram.sv
rtl/r2nv_seq.sv
rtl/r2nv_csc.sv
rtl/rgb_to_nv12_converter.sv
dv/tb_top.sv
